/* rtl/ita_pkg.sv */
// Shared types, character codes and helpers for the integer-to-ASCII formatter.
package ita_pkg;

    localparam int RESULT_SLOTS = 20;

    localparam logic CMD_DEC = 1'b0;
    localparam logic CMD_HEX = 1'b1;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_X     = 7'h78;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_UPPER_A = 7'h41;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_PREFIX,
        ST_SCAN,
        ST_DIGITS
    } state_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_DABBLE,
        OP_SHIFT_BIN,
        OP_MOVE
    } cell_op_t;

    function automatic logic [6:0] hex_char(input logic [3:0] d);
        logic [6:0] c;
        if (d < 4'd10)
        begin
            c = CH_ZERO + {3'b000, d};
        end
        else
        begin
            c = CH_UPPER_A + {3'b000, d} - 7'd10;
        end
        return c;
    endfunction

endpackage

/* rtl/ita_digit_cell.sv */
// One digit cell: double-dabble or binary shift step, or digit move to the neighbor.
module ita_digit_cell
    import ita_pkg::*;
(
    input  logic       clk,
    input  cell_op_t   op,
    input  logic       carry_in,
    input  logic [3:0] digit_in,
    output logic       carry_out,
    output logic [3:0] digit
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] corr;

    always_comb
    begin
        corr = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
        case (op)
            OP_HOLD:      digit_next = digit_reg;
            OP_CLEAR:     digit_next = 4'd0;
            OP_DABBLE:    digit_next = {corr[2:0], carry_in};
            OP_SHIFT_BIN: digit_next = {digit_reg[2:0], carry_in};
            OP_MOVE:      digit_next = digit_in;
            default:      digit_next = digit_reg;
        endcase
        carry_out = (op == OP_DABBLE) ? corr[3] : digit_reg[3];
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;

endmodule

/* rtl/integer_to_ascii_formatter.sv */
// Top level: integer-to-ASCII formatter with a row of digit cells and a control sequencer.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | cmd, value
//  out     | output    | out_valid/out_stall| ch, last
//
// An item takes VALUE_BITS bit-serial shifts through the cell row, then one digit move
// per cycle at the top of the row, skipping leading zeros; a move that emits a digit
// waits while the output is stalled.
// rst_n clears the sequencer and the output valid at once; cell digits are cleared on load.
// out_stall holds the prefix and digit phases; conversion runs on regardless.
// in_stall is high from the accepting edge until the final character is loaded.
module integer_to_ascii_formatter
    import ita_pkg::*;
#(
    parameter int VALUE_BITS = 64,
    parameter int MAX_DIGITS = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [63:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  ch,
    output logic        last
);

    localparam int NCELL = MAX_DIGITS;
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int BIT_W = $clog2(VALUE_BITS);
    localparam int CAP_POS = (MAX_DIGITS < RESULT_SLOTS) ? MAX_DIGITS : RESULT_SLOTS;
    localparam int CAP_NEG = (MAX_DIGITS < RESULT_SLOTS - 1) ? MAX_DIGITS : RESULT_SLOTS - 1;
    localparam int CAP_HEX = (MAX_DIGITS < RESULT_SLOTS - 2) ? MAX_DIGITS : RESULT_SLOTS - 2;

    state_t                  state_reg, state_next;
    logic [VALUE_BITS-1:0]   shift_reg, shift_next;
    logic [BIT_W-1:0]        bit_cnt_reg, bit_cnt_next;
    logic                    hex_reg, hex_next;
    logic [1:0]              pfx_reg, pfx_next;
    logic [CNT_W-1:0]        rem_reg, rem_next;
    logic [CNT_W-1:0]        cap_reg, cap_next;
    logic                    out_valid_reg, out_valid_next;
    logic [6:0]              ch_reg, ch_next;
    logic                    last_reg, last_next;

    logic [VALUE_BITS-1:0]   value_v;
    logic [VALUE_BITS-1:0]   mag;
    logic                    neg;
    logic                    adv;
    logic                    skip;
    cell_op_t                op;
    logic [3:0]              top_digit;

    logic [NCELL-1:0]        carry;
    logic [3:0]              digits [NCELL];

    assign value_v = value[VALUE_BITS-1:0];
    assign neg = (cmd == CMD_DEC) && value_v[VALUE_BITS-1];
    assign mag = neg ? (~value_v + VALUE_BITS'(1)) : value_v;
    assign adv = !out_valid_reg || !out_stall;
    assign top_digit = digits[NCELL-1];
    assign skip = (rem_reg > cap_reg) || ((top_digit == 4'd0) && (rem_reg > CNT_W'(1)));

    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                ita_digit_cell u_cell (
                    .clk       (clk),
                    .op        (op),
                    .carry_in  (shift_reg[VALUE_BITS-1]),
                    .digit_in  (4'd0),
                    .carry_out (carry[gi]),
                    .digit     (digits[gi])
                );
            end
            else
            begin : g_rest
                ita_digit_cell u_cell (
                    .clk       (clk),
                    .op        (op),
                    .carry_in  (carry[gi-1]),
                    .digit_in  (digits[gi-1]),
                    .carry_out (carry[gi]),
                    .digit     (digits[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (bit_cnt_reg == '0)
                begin
                    state_next = (pfx_reg != 2'd0) ? ST_PREFIX : ST_SCAN;
                end
            end
            ST_PREFIX:
            begin
                if (adv && (pfx_reg == 2'd1))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!skip)
                begin
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (adv && (rem_reg == CNT_W'(1)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        shift_next     = shift_reg;
        bit_cnt_next   = bit_cnt_reg;
        hex_next       = hex_reg;
        pfx_next       = pfx_reg;
        rem_next       = rem_reg;
        cap_next       = cap_reg;
        ch_next        = ch_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        op             = OP_HOLD;
        in_stall       = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op           = OP_CLEAR;
                    shift_next   = mag;
                    bit_cnt_next = BIT_W'(VALUE_BITS - 1);
                    hex_next     = (cmd == CMD_HEX);
                    if (cmd == CMD_HEX)
                    begin
                        pfx_next = 2'd2;
                        cap_next = CNT_W'(CAP_HEX);
                    end
                    else if (neg)
                    begin
                        pfx_next = 2'd1;
                        cap_next = CNT_W'(CAP_NEG);
                    end
                    else
                    begin
                        pfx_next = 2'd0;
                        cap_next = CNT_W'(CAP_POS);
                    end
                end
            end
            ST_CONV:
            begin
                op           = hex_reg ? OP_SHIFT_BIN : OP_DABBLE;
                shift_next   = {shift_reg[VALUE_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - BIT_W'(1);
                rem_next     = CNT_W'(NCELL);
            end
            ST_PREFIX:
            begin
                if (adv)
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b0;
                    pfx_next       = pfx_reg - 2'd1;
                    if (hex_reg)
                    begin
                        ch_next = (pfx_reg == 2'd2) ? CH_ZERO : CH_X;
                    end
                    else
                    begin
                        ch_next = CH_MINUS;
                    end
                end
            end
            ST_SCAN:
            begin
                if (skip)
                begin
                    op       = OP_MOVE;
                    rem_next = rem_reg - CNT_W'(1);
                end
            end
            ST_DIGITS:
            begin
                if (adv)
                begin
                    op             = OP_MOVE;
                    out_valid_next = 1'b1;
                    ch_next        = hex_char(top_digit);
                    last_next      = (rem_reg == CNT_W'(1));
                    rem_next       = rem_reg - CNT_W'(1);
                end
            end
            default: op = OP_HOLD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pfx_reg       <= 2'd0;
            rem_reg       <= '0;
            bit_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pfx_reg       <= pfx_next;
            rem_reg       <= rem_next;
            bit_cnt_reg   <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        hex_reg   <= hex_next;
        cap_reg   <= cap_next;
        ch_reg    <= ch_next;
        last_reg  <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign ch        = ch_reg;
    assign last      = last_reg;

    a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_CONV))
        else $error("accepted beat did not start conversion");

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGITS && adv && rem_reg == CNT_W'(1))
        |=> (state_reg == ST_IDLE && out_valid && last))
        else $error("final digit did not close the item");

    a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_DIGITS) |-> (rem_reg != '0))
        else $error("digit counter ran out during emission");

    a_decimal_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGITS && !hex_reg) |-> (top_digit <= 4'd9))
        else $error("decimal cell holds a non-decimal digit");

endmodule
